/* hw/rtl/complex_arithmetic_unit_top_assert.svh */
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge, quiet while reset is high.
`define CAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/cau_pkg.sv */
// Types and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = 2 * DATA_W + 1;
   localparam int NUM_W  = 2 * DATA_W + FRAC_W;
   localparam int HI_W   = DATA_W + FRAC_W;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_MAG = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic [1:0]               status;
   } rsp_type;

   // Sideband that rides along the divider stages.
   typedef struct packed {
      logic              is_div;
      logic              den_zero;
      logic              neg_re;
      logic              neg_im;
      logic              ovf_re;
      logic              ovf_im;
      logic              sat_plain;
      logic [DATA_W-1:0] plain_re;
      logic [DATA_W-1:0] plain_im;
   } side_type;

endpackage

/* hw/rtl/cau_div_pipe.sv */
// Restoring divider pipeline, one quotient bit per stage, two lanes sharing one divisor.
`timescale 1ns / 1ps
module cau_div_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [cau_pkg::PROD_W-1:0] in_den,
   input  logic [cau_pkg::PROD_W-1:0] in_rem_re,
   input  logic [cau_pkg::DATA_W-1:0] in_lo_re,
   input  logic [cau_pkg::PROD_W-1:0] in_rem_im,
   input  logic [cau_pkg::DATA_W-1:0] in_lo_im,
   input  cau_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [cau_pkg::DATA_W-1:0] out_q_re,
   output logic [cau_pkg::DATA_W-1:0] out_q_im,
   output cau_pkg::side_type          out_side
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int PW = cau_pkg::PROD_W;

   logic          valid_ff  [1:DW];
   logic [PW-1:0] den_ff    [1:DW];
   logic [PW-1:0] rem_re_ff [1:DW];
   logic [PW-1:0] rem_im_ff [1:DW];
   logic [DW-1:0] lo_re_ff  [1:DW];
   logic [DW-1:0] lo_im_ff  [1:DW];
   logic [DW-1:0] q_re_ff   [1:DW];
   logic [DW-1:0] q_im_ff   [1:DW];
   cau_pkg::side_type side_ff [1:DW];

   // One shift-compare-subtract step: returns {quotient bit, new remainder}.
   function automatic logic [PW:0] div_step(input logic [PW-1:0] rem,
                                            input logic          nbit,
                                            input logic [PW-1:0] den);
      logic [PW:0] t;
      logic [PW:0] d;
      logic        ge;
      t  = {rem, nbit};
      d  = {1'b0, den};
      ge = (t >= d);
      div_step = ge ? {1'b1, PW'(t - d)} : {1'b0, t[PW-1:0]};
   endfunction

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic                src_valid;
      logic [PW-1:0]       src_den;
      logic [PW-1:0]       src_rem_re;
      logic [PW-1:0]       src_rem_im;
      logic [DW-1:0]       src_lo_re;
      logic [DW-1:0]       src_lo_im;
      logic [DW-1:0]       src_q_re;
      logic [DW-1:0]       src_q_im;
      cau_pkg::side_type   src_side;
      logic [PW:0]         step_re;
      logic [PW:0]         step_im;

      if (k == 0) begin : g_first
         assign src_valid  = in_valid;
         assign src_den    = in_den;
         assign src_rem_re = in_rem_re;
         assign src_rem_im = in_rem_im;
         assign src_lo_re  = in_lo_re;
         assign src_lo_im  = in_lo_im;
         assign src_q_re   = '0;
         assign src_q_im   = '0;
         assign src_side   = in_side;
      end else begin : g_next
         assign src_valid  = valid_ff[k];
         assign src_den    = den_ff[k];
         assign src_rem_re = rem_re_ff[k];
         assign src_rem_im = rem_im_ff[k];
         assign src_lo_re  = lo_re_ff[k];
         assign src_lo_im  = lo_im_ff[k];
         assign src_q_re   = q_re_ff[k];
         assign src_q_im   = q_im_ff[k];
         assign src_side   = side_ff[k];
      end

      assign step_re = div_step(src_rem_re, src_lo_re[DW-1], src_den);
      assign step_im = div_step(src_rem_im, src_lo_im[DW-1], src_den);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[k+1]    <= src_den;
         rem_re_ff[k+1] <= step_re[PW-1:0];
         rem_im_ff[k+1] <= step_im[PW-1:0];
         lo_re_ff[k+1]  <= {src_lo_re[DW-2:0], 1'b0};
         lo_im_ff[k+1]  <= {src_lo_im[DW-2:0], 1'b0};
         q_re_ff[k+1]   <= {src_q_re[DW-2:0], step_re[PW]};
         q_im_ff[k+1]   <= {src_q_im[DW-2:0], step_im[PW]};
         side_ff[k+1]   <= src_side;
      end
   end

   assign out_valid = valid_ff[DW];
   assign out_q_re  = q_re_ff[DW];
   assign out_q_im  = q_im_ff[DW];
   assign out_side  = side_ff[DW];

endmodule

/* hw/rtl/complex_arithmetic_unit_top.sv */
// Top level of the complex arithmetic unit: operand stages, multipliers, divider, result register.
`timescale 1ns / 1ps
//
// Complex arithmetic unit, signed Q16.16 operands and results.
// Input channel: drive req_data (cmd, a, b) and raise start; the beat is
// taken at any rising edge where start is high and busy is low. busy stays
// low, so a new beat may enter on every cycle.
// Operations: add, subtract, multiply, divide, squared magnitude of a.
// Unknown codes give 0 + 0i with status ok.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_data
// (res_re, res_im, status); the receiver cannot stall, so nothing holds.
// Every beat passes the input register, multipliers, product sums,
// numerator prep, one divider stage per quotient bit, then the result
// register. Throughput is one beat per clock; beats leave in order.
// Reset (synchronous, active high) clears every valid bit; beats in flight
// are dropped and no strobe follows until new beats arrive.
//
module complex_arithmetic_unit_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cau_pkg::rsp_type rsp_data
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int FW = cau_pkg::FRAC_W;
   localparam int PW = cau_pkg::PROD_W;
   localparam int SW = cau_pkg::SUM_W;
   localparam int NW = cau_pkg::NUM_W;
   localparam int HW = cau_pkg::HI_W;
   localparam int LATENCY = 5 + DW;

   logic accept;

   // Never hold off the sender: every stage advances on every clock.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Clamp a wide signed value to DW bits: returns {saturated, value}.
   function automatic logic [DW:0] clamp(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = $signed({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
      lo = $signed({{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}});
      if (v > hi) begin
         clamp = {1'b1, cau_pkg::MAX_VAL};
      end else if (v < lo) begin
         clamp = {1'b1, cau_pkg::MIN_VAL};
      end else begin
         clamp = {1'b0, v[DW-1:0]};
      end
   endfunction

   // Finish one quotient lane: apply sign and clamp. Returns {saturated, value}.
   function automatic logic [DW:0] finish_q(input logic [DW-1:0] q,
                                            input logic          ovf,
                                            input logic          neg);
      logic [DW-1:0] lim;
      logic          sat;
      lim = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      sat = ovf || (q > lim);
      if (sat) begin
         finish_q = {1'b1, neg ? cau_pkg::MIN_VAL : cau_pkg::MAX_VAL};
      end else begin
         finish_q = {1'b0, neg ? DW'(-q) : q};
      end
   endfunction

   // ---------------- stage 1: input register ----------------
   logic             v1_ff;
   cau_pkg::req_type req1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      req1_ff <= req_data;
   end

   // ---------------- stage 2: products and plain add/sub ----------------
   // Magnitude reuses the first two multipliers as a_re^2 and a_im^2.
   logic signed [DW-1:0] y0;
   logic signed [DW-1:0] y1;
   logic signed [DW:0]   as_re_in;
   logic signed [DW:0]   as_im_in;

   always_comb begin
      y0 = (req1_ff.cmd == cau_pkg::CMD_MAG) ? req1_ff.a_re : req1_ff.b_re;
      y1 = (req1_ff.cmd == cau_pkg::CMD_MAG) ? req1_ff.a_im : req1_ff.b_im;
      if (req1_ff.cmd == cau_pkg::CMD_SUB) begin
         as_re_in = $signed({req1_ff.a_re[DW-1], req1_ff.a_re})
                  - $signed({req1_ff.b_re[DW-1], req1_ff.b_re});
         as_im_in = $signed({req1_ff.a_im[DW-1], req1_ff.a_im})
                  - $signed({req1_ff.b_im[DW-1], req1_ff.b_im});
      end else begin
         as_re_in = $signed({req1_ff.a_re[DW-1], req1_ff.a_re})
                  + $signed({req1_ff.b_re[DW-1], req1_ff.b_re});
         as_im_in = $signed({req1_ff.a_im[DW-1], req1_ff.a_im})
                  + $signed({req1_ff.b_im[DW-1], req1_ff.b_im});
      end
   end

   logic                 v2_ff;
   logic [2:0]           cmd2_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DW:0]   as_re2_ff, as_im2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd2_ff   <= req1_ff.cmd;
      p0_ff     <= PW'(req1_ff.a_re * y0);
      p1_ff     <= PW'(req1_ff.a_im * y1);
      p2_ff     <= PW'(req1_ff.a_re * req1_ff.b_im);
      p3_ff     <= PW'(req1_ff.a_im * req1_ff.b_re);
      p4_ff     <= PW'(req1_ff.b_re * req1_ff.b_re);
      p5_ff     <= PW'(req1_ff.b_im * req1_ff.b_im);
      as_re2_ff <= as_re_in;
      as_im2_ff <= as_im_in;
   end

   // ---------------- stage 3: product sums and divisor ----------------
   logic signed [SW-1:0] p0_x, p1_x, p2_x, p3_x;

   assign p0_x = $signed({p0_ff[PW-1], p0_ff});
   assign p1_x = $signed({p1_ff[PW-1], p1_ff});
   assign p2_x = $signed({p2_ff[PW-1], p2_ff});
   assign p3_x = $signed({p3_ff[PW-1], p3_ff});

   logic                 v3_ff;
   logic [2:0]           cmd3_ff;
   logic signed [SW-1:0] sr3_ff, si3_ff;
   logic [PW-1:0]        den3_ff;
   logic signed [DW:0]   as_re3_ff, as_im3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd3_ff   <= cmd2_ff;
      sr3_ff    <= (cmd2_ff == cau_pkg::CMD_MUL) ? p0_x - p1_x : p0_x + p1_x;
      si3_ff    <= (cmd2_ff == cau_pkg::CMD_DIV) ? p3_x - p2_x : p2_x + p3_x;
      den3_ff   <= $unsigned(p4_ff) + $unsigned(p5_ff);
      as_re3_ff <= as_re2_ff;
      as_im3_ff <= as_im2_ff;
   end

   // ---------------- stage 4: plain results and numerator prep ----------------
   logic [DW:0]   cl_re, cl_im;
   logic [SW-1:0] mag_re, mag_im;
   logic [NW-1:0] num_re, num_im;
   logic          neg_re, neg_im;
   cau_pkg::side_type side_in;

   always_comb begin
      cl_re  = '0;
      cl_im  = '0;
      case (cmd3_ff)
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
            cl_re = clamp($signed({{(SW-DW-1){as_re3_ff[DW]}}, as_re3_ff}));
            cl_im = clamp($signed({{(SW-DW-1){as_im3_ff[DW]}}, as_im3_ff}));
         end
         cau_pkg::CMD_MUL: begin
            cl_re = clamp(sr3_ff >>> FW);
            cl_im = clamp(si3_ff >>> FW);
         end
         cau_pkg::CMD_MAG: begin
            cl_re = clamp(sr3_ff >>> FW);
         end
         default: begin
            cl_re = '0;
            cl_im = '0;
         end
      endcase

      neg_re = sr3_ff[SW-1];
      neg_im = si3_ff[SW-1];
      mag_re = neg_re ? SW'(-sr3_ff) : sr3_ff;
      mag_im = neg_im ? SW'(-si3_ff) : si3_ff;
      num_re = NW'(mag_re[PW-1:0]) << FW;
      num_im = NW'(mag_im[PW-1:0]) << FW;

      side_in.is_div    = (cmd3_ff == cau_pkg::CMD_DIV);
      side_in.den_zero  = (den3_ff == '0);
      side_in.neg_re    = neg_re;
      side_in.neg_im    = neg_im;
      // A high part at or above the divisor means a quotient of 2^DW or more.
      side_in.ovf_re    = (PW'(num_re[NW-1:DW]) >= den3_ff);
      side_in.ovf_im    = (PW'(num_im[NW-1:DW]) >= den3_ff);
      side_in.sat_plain = cl_re[DW] || cl_im[DW];
      side_in.plain_re  = cl_re[DW-1:0];
      side_in.plain_im  = cl_im[DW-1:0];
   end

   logic              v4_ff;
   logic [PW-1:0]     den4_ff;
   logic [HW-1:0]     hi_re4_ff, hi_im4_ff;
   logic [DW-1:0]     lo_re4_ff, lo_im4_ff;
   cau_pkg::side_type side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      den4_ff   <= den3_ff;
      hi_re4_ff <= num_re[NW-1:DW];
      hi_im4_ff <= num_im[NW-1:DW];
      lo_re4_ff <= num_re[DW-1:0];
      lo_im4_ff <= num_im[DW-1:0];
      side4_ff  <= side_in;
   end

   // ---------------- divider stages ----------------
   logic              dv_valid;
   logic [DW-1:0]     dv_q_re, dv_q_im;
   cau_pkg::side_type dv_side;

   cau_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_den    (den4_ff),
      .in_rem_re (PW'(hi_re4_ff)),
      .in_lo_re  (lo_re4_ff),
      .in_rem_im (PW'(hi_im4_ff)),
      .in_lo_im  (lo_im4_ff),
      .in_side   (side4_ff),
      .out_valid (dv_valid),
      .out_q_re  (dv_q_re),
      .out_q_im  (dv_q_im),
      .out_side  (dv_side)
   );

   // ---------------- result register ----------------
   logic [DW:0]      fq_re, fq_im;
   cau_pkg::rsp_type rsp_in;
   logic             rsp_strobe_ff;
   cau_pkg::rsp_type rsp_data_ff;

   always_comb begin
      fq_re = finish_q(dv_q_re, dv_side.ovf_re, dv_side.neg_re);
      fq_im = finish_q(dv_q_im, dv_side.ovf_im, dv_side.neg_im);
      if (!dv_side.is_div) begin
         rsp_in.res_re = dv_side.plain_re;
         rsp_in.res_im = dv_side.plain_im;
         rsp_in.status = dv_side.sat_plain ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else if (dv_side.den_zero) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = cau_pkg::ST_DIV_ZERO;
      end else begin
         rsp_in.res_re = fq_re[DW-1:0];
         rsp_in.res_im = fq_im[DW-1:0];
         rsp_in.status = (fq_re[DW] || fq_im[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------- assertions ----------------
`include "complex_arithmetic_unit_top_assert.svh"

   `CAU_ASSERT(a_strobe_latency, clock, reset,
      rsp_strobe |-> $past(accept, LATENCY),
      "strobe without a beat accepted LATENCY cycles earlier")
   `CAU_ASSERT(a_div_zero_result, clock, reset,
      (rsp_strobe && rsp_data.status == cau_pkg::ST_DIV_ZERO)
         |-> (rsp_data.res_re == '0 && rsp_data.res_im == '0),
      "divide by zero with nonzero result")
   `CAU_ASSERT(a_sat_extreme, clock, reset,
      (rsp_strobe && rsp_data.status == cau_pkg::ST_SAT)
         |-> (rsp_data.res_re == cau_pkg::MAX_VAL || rsp_data.res_re == cau_pkg::MIN_VAL
              || rsp_data.res_im == cau_pkg::MAX_VAL || rsp_data.res_im == cau_pkg::MIN_VAL),
      "saturated status without a clamped part")
   `CAU_ASSERT_ALWAYS(a_reset_clears, clock,
      $past(reset) |-> !rsp_strobe,
      "strobe right after reset")

endmodule
